FILE: hdl/lav_pkg.sv
// Shared types, constants and fixed-point helpers of the look-at view matrix block.
`timescale 1ns / 1ps
package lav_pkg;

    localparam int FRAC_BITS = 16;
    // unit vector component width: magnitude never exceeds 2^FRAC_BITS
    localparam int DW = FRAC_BITS + 2;
    // quotient width of the normalizer divider
    localparam int QW = FRAC_BITS + 1;
    localparam int SQRT_STEPS = 32;
    localparam int NORM_STAGES = 2 + 6 + 2 + SQRT_STEPS + 1 + QW + 1;
    localparam int ROW_STAGES = 7;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_CAMUP = 2'd1;
    localparam logic [1:0] ROW_DIR   = 2'd2;

    localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        logic [2:0][31:0]   eye;
        logic [2:0][31:0]   up;
        logic [2:0][DW-1:0] dir;
        logic               degen;
    } side_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        word_t shift;
    } row_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // round v / 2^FRAC_BITS half away from zero
    function automatic logic [63:0] round_frac(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = mag64(v);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? (~r + 64'd1) : r;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        if ($signed(v) > WORD_MAX) begin
            return WORD_MAX[31:0];
        end
        if ($signed(v) < WORD_MIN) begin
            return WORD_MIN[31:0];
        end
        return v[31:0];
    endfunction

endpackage

FILE: hdl/look_at_view_matrix.sv
// Top level of the look-at view matrix block: input stage, pipeline and row output.
`timescale 1ns / 1ps
// Usage:
//   s_ channel: one transaction carries eye, center and up points (signed Q16.16).
//   m_ channel: each input transaction yields three row transactions, in the order
//   right (row_index 0), camera up (1), direction (2); last_row marks the third.
//   Every row carries row_shift = -dot(row, eye) and the shared degenerate flag.
// Output: the first row leaves after the input, difference, normalizer, cross, normalizer,
//   row and output stages; the other rows follow one per cycle while m_ready is high.
// Input rate: the output stage sends the three rows of an item over the single m_ channel
//   and takes no new item until its last row is accepted. The whole pipeline moves on one
//   advance enable, so items enter back to back while the output stage has room.
// Reset: aresetn (synchronous, active low) clears all valid bits and the row
//   counter; the pipeline is empty and s_ready is high after reset.
// Stall: while the output stage holds an item and its last row is not taken, every pipeline
//   stage holds and s_ready is low, so nothing is lost or repeated.
module look_at_view_matrix import lav_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_eye_x,
    input  logic [31:0] s_eye_y,
    input  logic [31:0] s_eye_z,
    input  logic [31:0] s_center_x,
    input  logic [31:0] s_center_y,
    input  logic [31:0] s_center_z,
    input  logic [31:0] s_up_x,
    input  logic [31:0] s_up_y,
    input  logic [31:0] s_up_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_row_index,
    output logic [31:0] m_row_x,
    output logic [31:0] m_row_y,
    output logic [31:0] m_row_z,
    output logic [31:0] m_row_shift,
    output logic        m_degenerate,
    output logic        m_last_row
);

    logic             adv;
    // input stage
    logic             in_vld_reg;
    logic [2:0][31:0] eye_reg;
    logic [2:0][31:0] ctr_reg;
    logic [2:0][31:0] up_reg;
    // difference stage
    logic             d_vld_reg;
    logic [2:0][63:0] d_reg;
    side_t            d_side_reg;

    logic               n1_valid;
    logic [2:0][DW-1:0] n1_dir;
    logic               n1_zero;
    side_t              n1_side;
    side_t              x_side_in;

    logic               x_valid;
    logic [2:0][63:0]   x_cr;
    side_t              x_side;

    logic               n2_valid;
    logic [2:0][DW-1:0] n2_right;
    logic               n2_zero;
    side_t              n2_side;
    side_t              r_side_in;

    logic               r_valid;
    row_t [2:0]         r_rows;
    logic               r_degen;

    // output stage
    logic               busy_reg;
    logic [1:0]         cnt_reg;
    row_t [2:0]         rows_reg;
    logic               degen_reg;

    // advance everything when the output stage is empty or sends its last row
    assign adv     = !busy_reg || (m_ready && (cnt_reg == ROW_DIR));
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            d_vld_reg  <= 1'b0;
        end else if (adv) begin
            in_vld_reg <= s_valid;
            d_vld_reg  <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            eye_reg <= {s_eye_z, s_eye_y, s_eye_x};
            ctr_reg <= {s_center_z, s_center_y, s_center_x};
            up_reg  <= {s_up_z, s_up_y, s_up_x};
            for (int i = 0; i < 3; i++) begin
                d_reg[i] <= 64'($signed(eye_reg[i])) - 64'($signed(ctr_reg[i]));
            end
            d_side_reg.eye   <= eye_reg;
            d_side_reg.up    <= up_reg;
            d_side_reg.dir   <= '0;
            d_side_reg.degen <= 1'b0;
        end
    end

    // dir = normalize(eye - center)
    lav_norm u_norm_dir (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (d_vld_reg),
        .in_v      (d_reg),
        .in_side   (d_side_reg),
        .out_valid (n1_valid),
        .out_n     (n1_dir),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    always_comb begin
        x_side_in       = n1_side;
        x_side_in.degen = n1_zero;
    end

    // up x dir, exact at doubled fraction width
    lav_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (n1_valid),
        .dir       (n1_dir),
        .in_side   (x_side_in),
        .out_valid (x_valid),
        .out_cr    (x_cr),
        .out_side  (x_side)
    );

    // right = normalize(up x dir)
    lav_norm u_norm_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (x_valid),
        .in_v      (x_cr),
        .in_side   (x_side),
        .out_valid (n2_valid),
        .out_n     (n2_right),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    always_comb begin
        r_side_in       = n2_side;
        r_side_in.degen = n2_side.degen | n2_zero;
    end

    lav_rows u_rows (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (n2_valid),
        .right     (n2_right),
        .in_side   (r_side_in),
        .out_valid (r_valid),
        .out_rows  (r_rows),
        .out_degen (r_degen)
    );

    // output stage: hold one item's rows and step through them
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= ROW_RIGHT;
        end else if (adv) begin
            busy_reg <= r_valid;
            cnt_reg  <= ROW_RIGHT;
        end else if (m_ready) begin
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rows_reg  <= r_rows;
            degen_reg <= r_degen;
        end
    end

    assign m_valid      = busy_reg;
    assign m_row_index  = cnt_reg;
    assign m_row_x      = rows_reg[cnt_reg].x;
    assign m_row_y      = rows_reg[cnt_reg].y;
    assign m_row_z      = rows_reg[cnt_reg].z;
    assign m_row_shift  = rows_reg[cnt_reg].shift;
    assign m_degenerate = degen_reg;
    assign m_last_row   = (cnt_reg == ROW_DIR);

endmodule

FILE: hdl/lav_norm.sv
// Pipelined vector normalizer: scale, square sum, square root and divide.
`timescale 1ns / 1ps
module lav_norm import lav_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [2:0][63:0]   in_v,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [2:0][DW-1:0] out_n,
    output logic               out_zero,
    output side_t              out_side
);

    localparam int S_MAG  = 0;
    localparam int S_MAX  = 1;
    localparam int S_SH0  = 2;
    localparam int S_SQ   = 8;
    localparam int S_SUM  = 9;
    localparam int S_RT0  = 10;
    localparam int S_DIV0 = S_RT0 + SQRT_STEPS;
    localparam int S_DQ0  = S_DIV0 + 1;
    localparam int S_FIN  = S_DQ0 + QW;

    typedef struct packed {
        logic [2:0]         sgn;
        logic [2:0][63:0]   a;
        logic [63:0]        mx;
        logic [2:0][59:0]   sq;
        logic [63:0]        x;
        logic [63:0]        res;
        logic [2:0][32:0]   rem;
        logic [2:0][QW-1:0] q;
        logic [2:0][DW-1:0] nv;
        logic               zero;
        side_t              side;
    } norm_t;

    function automatic norm_t step(input int s, input norm_t p);
        norm_t       n;
        int          k;
        logic [63:0] bitv;
        logic [63:0] t;
        logic [32:0] r2;
        logic [DW-1:0] tu;
        n = p;
        if (s == S_MAG) begin
            for (int i = 0; i < 3; i++) begin
                n.sgn[i] = p.a[i][63];
                n.a[i]   = mag64(p.a[i]);
            end
        end else if (s == S_MAX) begin
            n.mx = p.a[0];
            if (p.a[1] > n.mx) begin
                n.mx = p.a[1];
            end
            if (p.a[2] > n.mx) begin
                n.mx = p.a[2];
            end
            n.zero = (n.mx == 64'd0);
        end else if (s < S_SQ) begin
            // shift the leading one of the largest magnitude to the top
            k = 32 >> (s - S_SH0);
            if ((p.mx >> (64 - k)) == 64'd0) begin
                n.mx = p.mx << k;
                for (int i = 0; i < 3; i++) begin
                    n.a[i] = p.a[i] << k;
                end
            end
        end else if (s == S_SQ) begin
            for (int i = 0; i < 3; i++) begin
                n.a[i]  = {34'd0, p.a[i][63:34]};
                n.sq[i] = p.a[i][63:34] * p.a[i][63:34];
            end
        end else if (s == S_SUM) begin
            n.x   = 64'(p.sq[0]) + 64'(p.sq[1]) + 64'(p.sq[2]);
            n.res = 64'd0;
        end else if (s < S_DIV0) begin
            bitv = 64'd1 << (62 - 2 * (s - S_RT0));
            t    = p.res + bitv;
            if (p.x >= t) begin
                n.x   = p.x - t;
                n.res = (p.res >> 1) + bitv;
            end else begin
                n.res = p.res >> 1;
            end
        end else if (s == S_DIV0) begin
            for (int i = 0; i < 3; i++) begin
                n.a[i]   = (p.a[i] << FRAC_BITS) + (p.res >> 1);
                n.rem[i] = n.a[i][QW+32:QW];
                n.q[i]   = '0;
            end
        end else if (s < S_FIN) begin
            k = FRAC_BITS - (s - S_DQ0);
            for (int i = 0; i < 3; i++) begin
                t  = p.a[i] >> k;
                r2 = {p.rem[i][31:0], t[0]};
                if (r2 >= p.res[32:0]) begin
                    n.rem[i] = r2 - p.res[32:0];
                    n.q[i]   = p.q[i] | (QW'(1) << k);
                end else begin
                    n.rem[i] = r2;
                end
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                tu = {1'b0, p.q[i]};
                if (p.zero) begin
                    n.nv[i] = '0;
                end else if (p.sgn[i]) begin
                    n.nv[i] = ~tu + 1'b1;
                end else begin
                    n.nv[i] = tu;
                end
            end
        end
        return n;
    endfunction

    norm_t                  in_st;
    norm_t                  st_next [NORM_STAGES];
    norm_t                  st_reg  [NORM_STAGES];
    logic [NORM_STAGES-1:0] vld_reg;

    always_comb begin
        in_st      = '0;
        in_st.a    = in_v;
        in_st.side = in_side;
        st_next[0] = step(0, in_st);
        for (int s = 1; s < NORM_STAGES; s++) begin
            st_next[s] = step(s, st_reg[s-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NORM_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < NORM_STAGES; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NORM_STAGES-1];
    assign out_n     = st_reg[NORM_STAGES-1].nv;
    assign out_zero  = st_reg[NORM_STAGES-1].zero;
    assign out_side  = st_reg[NORM_STAGES-1].side;

endmodule

FILE: hdl/lav_cross.sv
// Cross product of the world up vector with the view direction.
`timescale 1ns / 1ps
module lav_cross import lav_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [2:0][DW-1:0] dir,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [2:0][63:0]   out_cr,
    output side_t              out_side
);

    logic signed [31+DW:0] prod_next [6];
    logic signed [31+DW:0] prod_reg  [6];
    side_t                 side_next;
    side_t                 side1_reg;
    side_t                 side2_reg;
    logic [2:0][63:0]      cr_reg;
    logic                  v1_reg;
    logic                  v2_reg;

    always_comb begin
        side_next     = in_side;
        side_next.dir = dir;
        prod_next[0]  = $signed(in_side.up[1]) * $signed(dir[2]);
        prod_next[1]  = $signed(in_side.up[2]) * $signed(dir[1]);
        prod_next[2]  = $signed(in_side.up[2]) * $signed(dir[0]);
        prod_next[3]  = $signed(in_side.up[0]) * $signed(dir[2]);
        prod_next[4]  = $signed(in_side.up[0]) * $signed(dir[1]);
        prod_next[5]  = $signed(in_side.up[1]) * $signed(dir[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 6; j++) begin
                prod_reg[j] <= prod_next[j];
            end
            side1_reg <= side_next;
            for (int i = 0; i < 3; i++) begin
                cr_reg[i] <= 64'(prod_reg[2*i]) - 64'(prod_reg[2*i+1]);
            end
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_cr    = cr_reg;
    assign out_side  = side2_reg;

endmodule

FILE: hdl/lav_rows.sv
// Camera up vector and the translation of the three view-matrix rows.
`timescale 1ns / 1ps
module lav_rows import lav_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [2:0][DW-1:0] right,
    input  side_t              in_side,
    output logic               out_valid,
    output row_t [2:0]         out_rows,
    output logic               out_degen
);

    typedef struct packed {
        logic [2:0][31:0] rt;
        logic [2:0][31:0] dir;
        logic [2:0][31:0] cu;
        logic [2:0][31:0] eye;
        logic [8:0][63:0] p;
        logic [2:0][63:0] acc;
        logic [2:0][31:0] sh;
        logic             degen;
    } rw_t;

    function automatic logic [31:0] row_elem(input rw_t r, input int k, input int i);
        if (k == 0) begin
            return r.rt[i];
        end
        if (k == 1) begin
            return r.cu[i];
        end
        return r.dir[i];
    endfunction

    function automatic rw_t step(input int s, input rw_t p);
        rw_t n;
        n = p;
        case (s)
            0: begin
                n.p[0] = $signed(p.dir[1]) * $signed(p.rt[2]);
                n.p[1] = $signed(p.dir[2]) * $signed(p.rt[1]);
                n.p[2] = $signed(p.dir[2]) * $signed(p.rt[0]);
                n.p[3] = $signed(p.dir[0]) * $signed(p.rt[2]);
                n.p[4] = $signed(p.dir[0]) * $signed(p.rt[1]);
                n.p[5] = $signed(p.dir[1]) * $signed(p.rt[0]);
            end
            1: begin
                for (int i = 0; i < 3; i++) begin
                    n.acc[i] = p.p[2*i] - p.p[2*i+1];
                end
            end
            2: begin
                for (int i = 0; i < 3; i++) begin
                    n.cu[i] = sat32(round_frac(p.acc[i]));
                end
            end
            3: begin
                for (int k = 0; k < 3; k++) begin
                    for (int i = 0; i < 3; i++) begin
                        n.p[3*k+i] = $signed(row_elem(p, k, i)) * $signed(p.eye[i]);
                    end
                end
            end
            4: begin
                for (int k = 0; k < 3; k++) begin
                    n.acc[k] = p.p[3*k] + p.p[3*k+1] + p.p[3*k+2];
                end
            end
            5: begin
                for (int k = 0; k < 3; k++) begin
                    n.acc[k] = round_frac(p.acc[k]);
                end
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    n.sh[k] = sat32(~p.acc[k] + 64'd1);
                end
            end
        endcase
        return n;
    endfunction

    rw_t                   in_st;
    rw_t                   st_next [ROW_STAGES];
    rw_t                   st_reg  [ROW_STAGES];
    logic [ROW_STAGES-1:0] vld_reg;
    rw_t                   fin;

    always_comb begin
        in_st       = '0;
        in_st.eye   = in_side.eye;
        in_st.degen = in_side.degen;
        for (int i = 0; i < 3; i++) begin
            in_st.rt[i]  = 32'($signed(right[i]));
            in_st.dir[i] = 32'($signed(in_side.dir[i]));
        end
        st_next[0] = step(0, in_st);
        for (int s = 1; s < ROW_STAGES; s++) begin
            st_next[s] = step(s, st_reg[s-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[ROW_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 0; s < ROW_STAGES; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign fin = st_reg[ROW_STAGES-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            out_rows[k].x     = row_elem(fin, k, 0);
            out_rows[k].y     = row_elem(fin, k, 1);
            out_rows[k].z     = row_elem(fin, k, 2);
            out_rows[k].shift = fin.sh[k];
        end
    end

    assign out_valid = vld_reg[ROW_STAGES-1];
    assign out_degen = fin.degen;

endmodule
